// ===== design/afds_pkg.sv =====
// Shared types and constants for the aspect-fit desktop size block.
package afds_pkg;

	// Width of every size field and register
	localparam int unsigned DIM_W = 14;
	// Width of the step counter of the shared divider, one quotient bit per step
	localparam int unsigned CNT_W = $clog2(DIM_W);

	typedef logic [DIM_W-1:0] dim_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_DISPLAY_WIDTH  = 2'd0,
		REG_DISPLAY_HEIGHT = 2'd1,
		REG_LIMIT_WIDTH    = 2'd2,
		REG_LIMIT_HEIGHT   = 2'd3
	} reg_idx_t;

	// Sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_GCD   = 9'b000000010,
		ST_DIVAW = 9'b000000100,
		ST_DIVAH = 9'b000001000,
		ST_DIVSW = 9'b000010000,
		ST_DIVSH = 9'b000100000,
		ST_MULW  = 9'b001000000,
		ST_MULH  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

endpackage

// ===== design/aspect_fit_desktop_size.sv =====
// Aspect-fit desktop size selector: top level with sequencer and shared divider.
//
// Input channel (in_valid/in_ready) takes one word: a requested desktop size.
// Output channel (out_valid/out_ready) returns one word per request: status,
// clamped desktop size, centred fit rectangle and flags.
// Registers are written on cfg_write with cfg_index/cfg_data; the user must write
// them only while idle, which the block itself does not enforce. An item runs
// through one 14-step restoring divider: Euclid's GCD of the display size
// (k remainder steps, at most about 20 for 14-bit values), then four quotients
// (aspect sides and the two scale factors), then the width and height products
// on one 14x14 multiplier. A zero request or unknown display goes straight
// from acceptance to the finish state. in_ready is high only when the
// sequencer idles.
// The output word sits in its own register, so the next request can be taken
// while a result waits; a finished item waits in place until the output
// register is free. Reset clears the configuration registers to 0 and leaves
// the block idle with no result pending; no clearing pass is needed.
module aspect_fit_desktop_size #(
	parameter int unsigned MAX_DIM = 8192,
	parameter int unsigned MIN_DIM = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  afds_pkg::dim_t      cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  afds_pkg::dim_t      request_width,
	input  afds_pkg::dim_t      request_height,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output afds_pkg::dim_t      desk_width,
	output afds_pkg::dim_t      desk_height,
	output afds_pkg::dim_t      rect_left,
	output afds_pkg::dim_t      rect_top,
	output afds_pkg::dim_t      fit_width,
	output afds_pkg::dim_t      fit_height,
	output logic                hit_max_limit,
	output logic                hit_aspect_limit,
	output logic                display_known,
	output logic                was_normalized
);
	import afds_pkg::*;

	localparam dim_t MAX_LIM = DIM_W'(MAX_DIM);
	localparam dim_t MIN_LIM = DIM_W'(MIN_DIM);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIM_W - 1);

	state_t state_q;

	// configuration
	dim_t disp_w_q, disp_h_q, lim_w_q, lim_h_q;

	// working registers
	dim_t req_w_q, req_h_q, dw_q, dh_q;
	dim_t x_q, y_q, aw_q, ah_q, sw_q, s_q, fw_q, fh_q;
	logic stat_q, known_q, hit_max_q, fit_ok_q;

	// shared divider
	dim_t                quo_q, rem_q, dvs_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIM_W:0]      shifted;
	logic                ge;
	dim_t                quo_n, rem_n;
	logic                div_last;

	// multiplier and misc
	dim_t                mul_a;
	logic [2*DIM_W-1:0]  prod;
	dim_t                s_min;
	logic                lim_w_ok, lim_h_ok, clamp_w, clamp_h, disp_ok, req_bad;
	logic                accept, out_free;
	dim_t                diff_w, diff_h;

	// output word
	logic out_valid_q;
	logic status_q, hit_max_o_q, hit_aspect_q, known_o_q, norm_q;
	dim_t desk_w_q, desk_h_q, left_q, top_q, fit_w_q, fit_h_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// divider step: one quotient bit
	assign shifted  = {rem_q, quo_q[DIM_W-1]};
	assign ge       = shifted >= {1'b0, dvs_q};
	assign rem_n    = ge ? DIM_W'(shifted - {1'b0, dvs_q}) : shifted[DIM_W-1:0];
	assign quo_n    = {quo_q[DIM_W-2:0], ge};
	assign div_last = (cnt_q == LAST_STEP);

	// one multiplier, width side then height side
	assign mul_a = (state_q == ST_MULW) ? aw_q : ah_q;
	assign prod  = (2*DIM_W)'(mul_a) * (2*DIM_W)'(s_q);

	// scale: smaller fitting factor, forced even
	assign s_min = (sw_q < quo_n) ? sw_q : quo_n;

	// limits outside the valid range are ignored
	assign lim_w_ok = (lim_w_q >= MIN_LIM) && (lim_w_q <= MAX_LIM);
	assign lim_h_ok = (lim_h_q >= MIN_LIM) && (lim_h_q <= MAX_LIM);
	assign clamp_w  = lim_w_ok && (request_width > lim_w_q);
	assign clamp_h  = lim_h_ok && (request_height > lim_h_q);
	assign disp_ok  = (disp_w_q != '0) && (disp_h_q != '0);
	assign req_bad  = (request_width == '0) || (request_height == '0);

	assign diff_w = dw_q - fw_q;
	assign diff_h = dh_q - fh_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_w_q <= '0;
			disp_h_q <= '0;
			lim_w_q  <= '0;
			lim_h_q  <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DISPLAY_WIDTH:  disp_w_q <= cfg_data;
				REG_DISPLAY_HEIGHT: disp_h_q <= cfg_data;
				REG_LIMIT_WIDTH:    lim_w_q  <= cfg_data;
				REG_LIMIT_HEIGHT:   lim_h_q  <= cfg_data;
				default:            ;
			endcase
		end
	end

	// sequencer and divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q) inside
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (req_bad || !disp_ok) ? ST_FIN : ST_GCD;
					end
				end
				ST_GCD, ST_DIVAW, ST_DIVAH, ST_DIVSW, ST_DIVSH: begin
					cnt_q <= div_last ? '0 : cnt_q + CNT_W'(1);
					if (div_last) begin
						unique case (state_q)
							ST_GCD:   state_q <= (rem_n == '0) ? ST_DIVAW : ST_GCD;
							ST_DIVAW: state_q <= ST_DIVAH;
							ST_DIVAH: state_q <= ST_DIVSW;
							ST_DIVSW: state_q <= ST_DIVSH;
							default:  state_q <= ST_MULW;
						endcase
					end
				end
				ST_MULW: state_q <= ST_MULH;
				ST_MULH: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: operand loads and divider registers
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (accept) begin
					req_w_q   <= request_width;
					req_h_q   <= request_height;
					dw_q      <= clamp_w ? lim_w_q : request_width;
					dh_q      <= clamp_h ? lim_h_q : request_height;
					hit_max_q <= clamp_w || clamp_h;
					stat_q    <= req_bad;
					known_q   <= !req_bad && disp_ok;
					fit_ok_q  <= 1'b0;
					x_q       <= disp_w_q;
					y_q       <= disp_h_q;
					quo_q     <= disp_w_q;
					dvs_q     <= disp_h_q;
					rem_q     <= '0;
				end
			end
			ST_GCD, ST_DIVAW, ST_DIVAH, ST_DIVSW, ST_DIVSH: begin
				if (!div_last) begin
					quo_q <= quo_n;
					rem_q <= rem_n;
				end else begin
					rem_q <= '0;
					unique case (state_q)
						ST_GCD: begin
							x_q <= y_q;
							y_q <= rem_n;
							if (rem_n == '0) begin
								// y is the divisor of both sides
								quo_q <= disp_w_q;
								dvs_q <= y_q;
							end else begin
								quo_q <= y_q;
								dvs_q <= rem_n;
							end
						end
						ST_DIVAW: begin
							aw_q  <= quo_n;
							quo_q <= disp_h_q;
							dvs_q <= x_q;
						end
						ST_DIVAH: begin
							ah_q  <= quo_n;
							quo_q <= dw_q;
							dvs_q <= aw_q;
						end
						ST_DIVSW: begin
							sw_q  <= quo_n;
							quo_q <= dh_q;
							dvs_q <= ah_q;
						end
						default: begin
							// one reduced side is odd, so the scale must be even
							s_q      <= {s_min[DIM_W-1:1], 1'b0};
							fit_ok_q <= (s_min[DIM_W-1:1] != '0);
						end
					endcase
				end
			end
			ST_MULW: fw_q <= prod[DIM_W-1:0];
			ST_MULH: fh_q <= prod[DIM_W-1:0];
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			status_q     <= stat_q;
			desk_w_q     <= known_q ? dw_q : req_w_q;
			desk_h_q     <= known_q ? dh_q : req_h_q;
			fit_w_q      <= (known_q && fit_ok_q) ? fw_q : req_w_q;
			fit_h_q      <= (known_q && fit_ok_q) ? fh_q : req_h_q;
			left_q       <= (known_q && fit_ok_q) ? {1'b0, diff_w[DIM_W-1:1]} : '0;
			top_q        <= (known_q && fit_ok_q) ? {1'b0, diff_h[DIM_W-1:1]} : '0;
			hit_max_o_q  <= known_q && hit_max_q;
			hit_aspect_q <= known_q && fit_ok_q && ((fw_q != dw_q) || (fh_q != dh_q));
			known_o_q    <= known_q;
			norm_q       <= known_q && fit_ok_q && hit_max_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign desk_width       = desk_w_q;
	assign desk_height      = desk_h_q;
	assign rect_left        = left_q;
	assign rect_top         = top_q;
	assign fit_width        = fit_w_q;
	assign fit_height       = fit_h_q;
	assign hit_max_limit    = hit_max_o_q;
	assign hit_aspect_limit = hit_aspect_q;
	assign display_known    = known_o_q;
	assign was_normalized   = norm_q;

endmodule

// ===== design/afds_chk.sv =====
// Port-level checks for the aspect-fit desktop size block, bound to the top level.
module afds_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input logic           status,
	input afds_pkg::dim_t desk_width,
	input afds_pkg::dim_t desk_height,
	input afds_pkg::dim_t rect_left,
	input afds_pkg::dim_t fit_width,
	input afds_pkg::dim_t fit_height,
	input logic           hit_max_limit,
	input logic           hit_aspect_limit,
	input logic           display_known,
	input logic           was_normalized
);
	import afds_pkg::*;

	// a held word keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fit_width) && $stable(desk_width))
		else $error("output word changed while stalled");

	// one request at a time: no acceptance on the following edge
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive edges");

	// a bad request carries no flags and no offset
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !display_known && !hit_max_limit && rect_left == '0)
		else $error("flags set on invalid request");

	// normalised only when clamped and known
	a_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_normalized |-> hit_max_limit && display_known)
		else $error("was_normalized without clamp");

	// fit rectangle lies within the desktop
	a_fit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit_aspect_limit |->
			fit_width <= desk_width && fit_height <= desk_height)
		else $error("fit rectangle exceeds desktop");

endmodule

bind aspect_fit_desktop_size afds_chk u_afds_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.status           (status),
	.desk_width       (desk_width),
	.desk_height      (desk_height),
	.rect_left        (rect_left),
	.fit_width        (fit_width),
	.fit_height       (fit_height),
	.hit_max_limit    (hit_max_limit),
	.hit_aspect_limit (hit_aspect_limit),
	.display_known    (display_known),
	.was_normalized   (was_normalized)
);

// ===== tb/tb_aspect_fit_desktop_size.sv =====
// Self-checking testbench for the aspect-fit desktop size block.
`timescale 1ns / 100ps

module tb_aspect_fit_desktop_size;

	import afds_pkg::*;

	localparam int unsigned MAX_DIM       = 8192;
	localparam int unsigned MIN_DIM       = 200;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam int unsigned CYCLE_LIMIT   = 2_500_000;
	// Longest item: about 20 Euclid steps plus four divisions
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned DRAIN_GAP     = 4;
	localparam int unsigned HOLD_CYCLES   = 1500;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_ITEMS   = 110;

	// One result word, fields in port order
	typedef struct packed {
		logic status;
		dim_t desk_width;
		dim_t desk_height;
		dim_t rect_left;
		dim_t rect_top;
		dim_t fit_width;
		dim_t fit_height;
		logic hit_max_limit;
		logic hit_aspect_limit;
		logic display_known;
		logic was_normalized;
	} fit_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	dim_t       cfg_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	dim_t       request_width = '0;
	dim_t       request_height = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       status;
	dim_t       desk_width;
	dim_t       desk_height;
	dim_t       rect_left;
	dim_t       rect_top;
	dim_t       fit_width;
	dim_t       fit_height;
	logic       hit_max_limit;
	logic       hit_aspect_limit;
	logic       display_known;
	logic       was_normalized;

	// Register copies used by the predictor
	dim_t disp_w = '0;
	dim_t disp_h = '0;
	dim_t lim_w = '0;
	dim_t lim_h = '0;

	fit_t        fits_pending[$];
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned requests_sent = 0;
	int unsigned invalid_seen = 0;
	int unsigned clamped_seen = 0;
	int unsigned letterboxed_seen = 0;
	int unsigned cfg_settings = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_requests = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;

	aspect_fit_desktop_size #(
		.MAX_DIM(MAX_DIM),
		.MIN_DIM(MIN_DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.request_width(request_width),
		.request_height(request_height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.desk_width(desk_width),
		.desk_height(desk_height),
		.rect_left(rect_left),
		.rect_top(rect_top),
		.fit_width(fit_width),
		.fit_height(fit_height),
		.hit_max_limit(hit_max_limit),
		.hit_aspect_limit(hit_aspect_limit),
		.display_known(display_known),
		.was_normalized(was_normalized)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, fits_pending.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Expected fit for one request under the current register copies
	function automatic fit_t fit_desktop(dim_t rw, dim_t rh);
		fit_t        r;
		int unsigned x, y, t, aw, ah, mw, mh, dw, dh, s;
		r = '0;
		r.desk_width  = rw;
		r.desk_height = rh;
		r.fit_width   = rw;
		r.fit_height  = rh;
		if (rw == 0 || rh == 0) begin
			r.status = 1'b1;
		end else if (disp_w != 0 && disp_h != 0) begin
			// reduce the display ratio
			x = disp_w;
			y = disp_h;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			aw = disp_w / x;
			ah = disp_h / x;
			// limits outside the legal window are ignored
			mw = (lim_w < MIN_DIM || lim_w > MAX_DIM) ? 0 : lim_w;
			mh = (lim_h < MIN_DIM || lim_h > MAX_DIM) ? 0 : lim_h;
			dw = rw;
			dh = rh;
			r.display_known = 1'b1;
			if (mw != 0 && dw > mw) begin
				dw = mw;
				r.hit_max_limit = 1'b1;
			end
			if (mh != 0 && dh > mh) begin
				dh = mh;
				r.hit_max_limit = 1'b1;
			end
			r.desk_width  = dim_t'(dw);
			r.desk_height = dim_t'(dh);
			// largest scale that fits, lowered until both sides are even
			s = (dw / aw < dh / ah) ? dw / aw : dh / ah;
			while (s > 0 && (((aw * s) & 1) != 0 || ((ah * s) & 1) != 0))
				s--;
			if (s > 0) begin
				r.fit_width        = dim_t'(aw * s);
				r.fit_height       = dim_t'(ah * s);
				r.rect_left        = dim_t'((dw - aw * s) / 2);
				r.rect_top         = dim_t'((dh - ah * s) / 2);
				r.hit_aspect_limit = (aw * s != dw || ah * s != dh);
				r.was_normalized   = r.hit_max_limit;
			end
		end
		return r;
	endfunction

	function automatic string fit_str(fit_t f);
		return $sformatf("st=%0d desk=%0dx%0d at=(%0d,%0d) fit=%0dx%0d max=%0d asp=%0d kn=%0d nrm=%0d",
			f.status, f.desk_width, f.desk_height, f.rect_left, f.rect_top,
			f.fit_width, f.fit_height, f.hit_max_limit, f.hit_aspect_limit,
			f.display_known, f.was_normalized);
	endfunction

	// Receiver: random stalls plus a long hold-off on request
	always @(posedge clk) begin : rx_stall
		int unsigned hold_seen;
		int unsigned hold_left;
		int unsigned gap_left;
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
			gap_left = $urandom_range(0, 13);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker: each accepted word against the oldest expectation
	always @(posedge clk) begin : fit_check
		fit_t got;
		fit_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {status, desk_width, desk_height, rect_left, rect_top,
				fit_width, fit_height, hit_max_limit, hit_aspect_limit,
				display_known, was_normalized};
			results_checked++;
			if (fits_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR unexpected result word: %s", fit_str(got));
			end else begin
				want = fits_pending.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("ERROR result %0d expected %s", results_checked,
							fit_str(want));
						$display("ERROR result %0d actual   %s", results_checked,
							fit_str(got));
					end
				end
			end
		end
	end

	// Offer one request word, with an optional idle burst first
	task automatic send_request(input dim_t w, input dim_t h);
		fit_t        want;
		int unsigned gap;
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		request_width  <= w;
		request_height <= h;
		do @(posedge clk); while (!in_ready);
		want = fit_desktop(w, h);
		fits_pending.push_back(want);
		requests_sent++;
		if (want.status) invalid_seen++;
		if (want.hit_max_limit) clamped_seen++;
		if (want.hit_aspect_limit) letterboxed_seen++;
	endtask

	// Stop offering and wait for every outstanding result
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (fits_pending.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input dim_t val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_DISPLAY_WIDTH:  disp_w = val;
			REG_DISPLAY_HEIGHT: disp_h = val;
			REG_LIMIT_WIDTH:    lim_w = val;
			default:            lim_h = val;
		endcase
	endtask

	// All four registers, written only once the block is idle
	task automatic set_geometry(input dim_t dw, input dim_t dh, input dim_t lw, input dim_t lh);
		wait_drained();
		write_reg(REG_DISPLAY_WIDTH, dw);
		write_reg(REG_DISPLAY_HEIGHT, dh);
		write_reg(REG_LIMIT_WIDTH, lw);
		write_reg(REG_LIMIT_HEIGHT, lh);
		cfg_settings++;
	endtask

	function automatic dim_t pick_request();
		case ($urandom_range(0, 24)) inside
			0:       return '0;
			[1:3]:   return dim_t'($urandom_range(16000, 16383));
			[4:9]:   return dim_t'($urandom_range(1, 600));
			default: return dim_t'($urandom_range(1, 16383));
		endcase
	endfunction

	function automatic dim_t pick_limit();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return dim_t'(MIN_DIM - 1);
			2:       return dim_t'(MIN_DIM);
			3:       return dim_t'(MAX_DIM);
			4:       return dim_t'(MAX_DIM + 1);
			5:       return dim_t'(16383);
			6:       return dim_t'($urandom_range(0, 16383));
			default: return dim_t'($urandom_range(MIN_DIM, MAX_DIM));
		endcase
	endfunction

	// Zero requests, and any request while the display size is unknown
	task automatic test_zero_and_unknown();
		send_request(14'd0, 14'd0);
		send_request(14'd0, 14'd16383);
		send_request(14'd16383, 14'd0);
		send_request(14'd16383, 14'd16383);
		send_request(14'd1, 14'd1);
		set_geometry(14'd1920, 14'd0, 14'd3840, 14'd2160);
		send_request(14'd3000, 14'd3000);
	endtask

	// Exact fit, clamps, letterboxing, scale of zero and limit edges
	task automatic test_directed_fit();
		set_geometry(14'd1920, 14'd1080, 14'd3840, 14'd2160);
		send_request(14'd1920, 14'd1080);
		send_request(14'd3840, 14'd2160);
		send_request(14'd16383, 14'd16383);
		send_request(14'd4000, 14'd1000);
		send_request(14'd15, 14'd9);
		send_request(14'd31, 14'd17);
		send_request(14'd32, 14'd18);
		send_request(14'd1366, 14'd768);
		send_request(14'd0, 14'd100);
		// square display, limits at the edges of the legal window
		set_geometry(14'd16383, 14'd16383, 14'd200, 14'd8192);
		send_request(14'd16383, 14'd16383);
		send_request(14'd199, 14'd5000);
		send_request(14'd1, 14'd1);
		// limits just outside the window are ignored
		set_geometry(14'd1, 14'd16383, 14'd199, 14'd8193);
		send_request(14'd16383, 14'd16383);
		send_request(14'd2, 14'd16383);
		set_geometry(14'd16382, 14'd2, 14'd8192, 14'd8191);
		send_request(14'd16383, 14'd16383);
	endtask

	// Random geometry per phase, random requests within it
	task automatic test_random_fit();
		int unsigned m;
		dim_t        dw, dh;
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 9)) inside
				0: begin
					dw = dim_t'($urandom_range(0, 1) ? 0 : $urandom_range(1, 16383));
					dh = (dw == 0) ? dim_t'($urandom_range(0, 16383)) : '0;
				end
				1: begin
					dw = $urandom_range(0, 1) ? 14'd1 : 14'd16383;
					dh = $urandom_range(0, 1) ? 14'd1 : 14'd16383;
				end
				[2:4]: begin
					dw = dim_t'($urandom_range(1, 16383));
					dh = dim_t'($urandom_range(1, 16383));
				end
				default: begin
					// small reduced ratio, so most requests get a fit
					m  = $urandom_range(1, 500);
					dw = dim_t'($urandom_range(1, 32) * m);
					dh = dim_t'($urandom_range(1, 32) * m);
					if (dw == 0) dw = 14'd16;
					if (dh == 0) dh = 14'd9;
				end
			endcase
			set_geometry(dw, dh, pick_limit(), pick_limit());
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			for (int unsigned i = 0; i < PHASE_ITEMS; i++)
				send_request(pick_request(), pick_request());
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Receiver holds off while requests keep coming, so the input stalls
	task automatic test_output_backpressure();
		set_geometry(14'd1920, 14'd1080, 14'd0, 14'd0);
		tx_idle_en = 1'b0;
		hold_requests++;
		for (int unsigned i = 0; i < 12; i++)
			send_request(dim_t'($urandom_range(1, 16383)), dim_t'($urandom_range(1, 16383)));
		tx_idle_en = 1'b1;
	endtask

	// Sender pauses with nothing in flight, then carries on
	task automatic test_drain_pause();
		set_geometry(14'd1280, 14'd800, 14'd1024, 14'd0);
		for (int unsigned i = 0; i < 10; i++)
			send_request(pick_request(), pick_request());
		wait_drained();
		for (int unsigned i = 0; i < 10; i++)
			send_request(pick_request(), pick_request());
	endtask

	// Closing stretch with no idling on either side
	task automatic test_steady_stream();
		set_geometry(14'd2560, 14'd1600, 14'd4096, 14'd4096);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int unsigned i = 0; i < 120; i++)
			send_request(pick_request(), pick_request());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_and_unknown();
		test_directed_fit();
		test_random_fit();
		test_output_backpressure();
		test_drain_pause();
		test_steady_stream();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatches += fits_pending.size();
		$display("Ran %0d requests over %0d register settings, %0d results checked",
			requests_sent, cfg_settings, results_checked);
		$display("Of these %0d zero-size, %0d clamped to a limit, %0d letterboxed",
			invalid_seen, clamped_seen, letterboxed_seen);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== aspect_fit_desktop_size.f =====
design/afds_pkg.sv
design/aspect_fit_desktop_size.sv
design/afds_chk.sv
tb/tb_aspect_fit_desktop_size.sv
